/* design/bfra_pkg.sv */
`timescale 1ns / 1ps
package bfra_pkg;

    localparam int ADDR_W      = 48;
    localparam int MAX_REGIONS = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int GROW_ORDER  = 21;
    localparam int MIN_REGION  = 24;
    localparam int T_W         = ADDR_W - GROW_ORDER;
    localparam int K_W         = 64 - GROW_ORDER + 1;
    localparam int IN_W        = 104;
    localparam int OUT_W       = 104;

    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}};
    localparam logic [ADDR_W-1:0] CHUNK     = ADDR_W'(1) << GROW_ORDER;
    localparam logic [ADDR_W-1:0] MIN_SZ    = ADDR_W'(MIN_REGION);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
    } t_entry;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OOM     = 3'd1,
        ST_SMALL   = 3'd2,
        ST_OVERLAP = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        RET_ALLOC,
        RET_FREE,
        RET_GROW
    } t_ret;

    typedef enum logic [4:0] {
        S_IDLE, S_A_RD, S_A_CHK, S_A_END, S_APPLY, S_DEL_RD, S_DEL_WR,
        S_I_RD, S_I_CMP, S_I_DEC, S_UP_RD, S_UP_WR, S_INS_OK,
        S_G_TOP, S_G_EXT, S_G_CA, S_G_CB, S_G_CK, S_G_CC, S_G_KFIN,
        S_G_APP, S_G_FIT, S_DONE
    } t_state;

    typedef struct packed {
        logic              fits;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] waste;
    } t_fit;

endpackage

/* design/bfra_ram.sv */
`timescale 1ns / 1ps
module bfra_ram #(
    parameter int AW = 6,
    parameter int DW = 96
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bfra_fit.sv */
`timescale 1ns / 1ps
module bfra_fit (
    input  bfra_pkg::t_entry              i_ent,
    input  logic [bfra_pkg::ADDR_W-1:0]   i_req,
    input  logic [bfra_pkg::ADDR_W-1:0]   i_amask,
    output bfra_pkg::t_fit                o_fit
);
    import bfra_pkg::*;

    logic [ADDR_W-1:0] w_end;
    logic [ADDR_W-1:0] w_top;
    logic [ADDR_W-1:0] w_base;

    // place at the region top, aligned down; waste is the bits cut off
    always_comb begin
        w_end  = i_ent.start + i_ent.size;
        w_top  = w_end - i_req;
        w_base = w_top & ~i_amask;
        o_fit.fits  = (i_ent.size >= i_req) && (w_base >= i_ent.start) &&
                      ((w_base == i_ent.start) || ((w_base - i_ent.start) >= MIN_SZ));
        o_fit.base  = w_base;
        o_fit.waste = w_top & i_amask;
    end

endmodule

/* design/best_fit_region_allocator_core.sv */
`timescale 1ns / 1ps
// Best-fit free-region allocator with coalescing.
// Input channel (s_axis): one transaction per request, either an allocate
// (size, alignment order) or a free (address, size). Output channel
// (m_axis): exactly one transaction per request with status, grant address
// and grant size. Configuration: i_cfg_we writes heap_base (index 0) or
// heap_limit (index 1); write only while no request is outstanding.
// The region table lives in one 64-entry single-port-read RAM; each table
// step reads an entry, waits for the registered read data, then decides or
// writes. An allocate scans the table region by region; insert and delete
// shifts move one entry at a time; each growth step adds a scan of the table.
// A request runs longest when growth maps one chunk per step into a long
// table; how long it runs is set by the table size, the number of growth
// steps and the RAM port.
// One request is worked on at a time; a new request is taken as soon as
// the previous result sits in the output register, even if the receiver
// stalls it. The output register holds its transaction until
// i_m_axis_tready. Reset (i_rst_n low, synchronous) empties the table,
// clears mapped bytes and both registers; no clearing pass is needed.
module best_fit_region_allocator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // op[0], req_addr[48:1], req_size[96:49], alignment[102:97], zero[103]
    input  logic [bfra_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // status[2:0], grant_addr[50:3], grant_size[98:51], zero[103:99]
    output logic [bfra_pkg::OUT_W-1:0]   o_m_axis_tdata,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [bfra_pkg::ADDR_W-1:0]  i_cfg_data
);
    import bfra_pkg::*;

    t_state            r_state, n_state;
    t_ret              r_ret, n_ret;
    logic [ADDR_W-1:0] r_base, r_limit;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_mapped, n_mapped;
    logic [ADDR_W-1:0] r_req, n_req;
    logic [5:0]        r_aord, n_aord;
    logic [CNT_W-1:0]  r_idx, n_idx, r_p, n_p, r_ci, n_ci;
    t_entry            r_prev, n_prev, r_next, n_next, r_cand, n_cand;
    logic              r_hp, n_hp, r_hn, n_hn;
    logic [ADDR_W-1:0] r_ia, n_ia, r_iz, n_iz;
    logic              r_have, n_have;
    logic [IDX_W-1:0]  r_best, n_best;
    t_entry            r_bent, n_bent;
    logic [ADDR_W-1:0] r_bbase, n_bbase, r_bwaste, n_bwaste;
    logic [T_W-1:0]    r_room, n_room, r_t, n_t;
    logic [K_W-1:0]    r_k, n_k;
    logic [63:0]       r_tv, n_tv;
    logic              r_step, n_step;
    t_status           r_st, n_st;
    logic [ADDR_W-1:0] r_ga, n_ga, r_gs, n_gs;
    logic              r_ovalid, n_ovalid;
    t_status           r_ostat, n_ostat;
    logic [ADDR_W-1:0] r_oga, n_oga, r_ogs, n_ogs;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    t_entry            mem_wdata, mem_rdata;
    t_entry            fit_ent;
    t_fit              fit;
    logic [ADDR_W-1:0] amask48;
    logic [63:0]       amask64;

    bfra_ram #(.AW(IDX_W), .DW($bits(t_entry))) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bfra_fit u_fit (
        .i_ent   (fit_ent),
        .i_req   (r_req),
        .i_amask (amask48),
        .o_fit   (fit)
    );

    assign amask48 = (r_aord >= 6'(ADDR_W)) ? ADDR_MASK : ((ADDR_W'(1) << r_aord) - ADDR_W'(1));
    assign amask64 = (64'd1 << r_aord) - 64'd1;
    assign fit_ent = (r_state == S_G_FIT) ? r_cand : mem_rdata;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'd0, r_ogs, r_oga, r_ostat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_mapped <= '0;
            r_base   <= '0;
            r_limit  <= '0;
            r_ovalid <= 1'b0;
            r_ret    <= RET_ALLOC;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_mapped <= n_mapped;
            r_ovalid <= n_ovalid;
            r_ret    <= n_ret;
            if (i_cfg_we) begin
                if (i_cfg_idx) begin
                    r_limit <= i_cfg_data;
                end else begin
                    r_base <= i_cfg_data;
                end
            end
        end
        r_req <= n_req;   r_aord <= n_aord;  r_idx <= n_idx;   r_p <= n_p;
        r_ci <= n_ci;     r_prev <= n_prev;  r_next <= n_next; r_cand <= n_cand;
        r_hp <= n_hp;     r_hn <= n_hn;      r_ia <= n_ia;     r_iz <= n_iz;
        r_have <= n_have; r_best <= n_best;  r_bent <= n_bent;
        r_bbase <= n_bbase; r_bwaste <= n_bwaste;
        r_room <= n_room; r_t <= n_t;        r_k <= n_k;       r_tv <= n_tv;
        r_step <= n_step; r_st <= n_st;      r_ga <= n_ga;     r_gs <= n_gs;
        r_ostat <= n_ostat; r_oga <= n_oga;  r_ogs <= n_ogs;
    end

    always_comb begin
        logic [ADDR_W:0]   end_ia;
        logic [ADDR_W-1:0] pe, lim, gsz, nsz, add, bb;
        logic [T_W-1:0]    tt;
        logic [48:0]       x;
        logic [K_W-1:0]    kk;
        logic              mp, ms;

        n_state = r_state;   n_ret = r_ret;     n_count = r_count;  n_mapped = r_mapped;
        n_req = r_req;       n_aord = r_aord;   n_idx = r_idx;      n_p = r_p;
        n_ci = r_ci;         n_prev = r_prev;   n_next = r_next;    n_cand = r_cand;
        n_hp = r_hp;         n_hn = r_hn;       n_ia = r_ia;        n_iz = r_iz;
        n_have = r_have;     n_best = r_best;   n_bent = r_bent;
        n_bbase = r_bbase;   n_bwaste = r_bwaste;
        n_room = r_room;     n_t = r_t;         n_k = r_k;          n_tv = r_tv;
        n_step = r_step;     n_st = r_st;       n_ga = r_ga;        n_gs = r_gs;
        n_ostat = r_ostat;   n_oga = r_oga;     n_ogs = r_ogs;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        mem_we = 1'b0;       mem_waddr = '0;    mem_wdata = '0;     mem_raddr = '0;

        end_ia = {1'b0, r_ia} + {1'b0, r_iz};
        pe     = r_prev.start + r_prev.size;
        mp     = r_hp && (pe == r_ia);
        ms     = r_hn && (end_ia == {1'b0, r_next.start});
        lim    = r_hn ? (r_next.start - ADDR_W'(1)) : ADDR_MASK;
        tt     = T_W'((lim - r_ia) >> GROW_ORDER);
        gsz    = r_req + r_bwaste;
        nsz    = r_bent.size - gsz;
        add    = ADDR_W'(r_t) << GROW_ORDER;
        bb     = (r_ia + (ADDR_W'(r_k[T_W-1:0]) << GROW_ORDER) - r_req) & ~amask48;
        x      = r_step ? ({1'b0, r_prev.start} + 49'(MIN_REGION)) : {1'b0, r_prev.start};
        kk     = (r_k == '0) ? K_W'(1) : r_k;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_req  = i_s_axis_tdata[96:49];
                    n_aord = i_s_axis_tdata[102:97];
                    n_st = ST_OK;  n_ga = '0;  n_gs = '0;
                    n_idx = '0;    n_hp = 1'b0; n_hn = 1'b0; n_have = 1'b0;
                    if (i_s_axis_tdata[0] == OP_FREE) begin
                        if (i_s_axis_tdata[96:49] < MIN_SZ) begin
                            n_st = ST_SMALL;
                            n_state = S_DONE;
                        end else begin
                            n_ia = i_s_axis_tdata[48:1];
                            n_iz = i_s_axis_tdata[96:49];
                            n_ret = RET_FREE;
                            n_state = S_I_RD;
                        end
                    end else begin
                        n_state = S_A_RD;
                    end
                end
            end
            S_A_RD: begin
                mem_raddr = r_idx[IDX_W-1:0];
                n_state = (r_idx == r_count) ? S_A_END : S_A_CHK;
            end
            S_A_CHK: begin
                n_state = S_A_RD;
                n_idx = r_idx + CNT_W'(1);
                if (fit.fits && (!r_have || fit.waste <= r_bwaste ||
                                 r_bent.size > mem_rdata.size)) begin
                    n_have = 1'b1;
                    n_best = r_idx[IDX_W-1:0];
                    n_bent = mem_rdata;
                    n_bbase = fit.base;
                    n_bwaste = fit.waste;
                    // exact fit ends the scan
                    if (fit.waste == '0 && mem_rdata.size == r_req) begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_A_END: begin
                n_state = r_have ? S_APPLY : S_G_TOP;
            end
            S_APPLY: begin
                n_st = ST_OK;
                n_ga = r_bbase;
                n_gs = gsz;
                if (nsz < MIN_SZ) begin
                    n_idx = CNT_W'(r_best);
                    n_ret = RET_ALLOC;
                    n_state = S_DEL_RD;
                end else begin
                    mem_we = 1'b1;
                    mem_waddr = r_best;
                    mem_wdata = '{start: r_bent.start, size: nsz};
                    n_state = S_DONE;
                end
            end
            S_DEL_RD: begin
                if (r_idx + CNT_W'(1) >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = (r_ret == RET_ALLOC) ? S_DONE : S_INS_OK;
                end else begin
                    mem_raddr = IDX_W'(r_idx + CNT_W'(1));
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                mem_we = 1'b1;
                mem_waddr = r_idx[IDX_W-1:0];
                mem_wdata = mem_rdata;
                n_idx = r_idx + CNT_W'(1);
                n_state = S_DEL_RD;
            end
            S_I_RD: begin
                mem_raddr = r_idx[IDX_W-1:0];
                if (r_idx == r_count) begin
                    n_hn = 1'b0;
                    n_state = (r_ret == RET_GROW) ? S_G_EXT : S_I_DEC;
                end else begin
                    n_state = S_I_CMP;
                end
            end
            S_I_CMP: begin
                if (mem_rdata.start <= r_ia) begin
                    n_hp = 1'b1;
                    n_prev = mem_rdata;
                    n_idx = r_idx + CNT_W'(1);
                    n_state = S_I_RD;
                end else begin
                    n_hn = 1'b1;
                    n_next = mem_rdata;
                    n_state = (r_ret == RET_GROW) ? S_G_EXT : S_I_DEC;
                end
            end
            S_I_DEC: begin
                n_p = r_idx;
                if (end_ia > {1'b0, ADDR_MASK} || (r_hp && pe > r_ia) ||
                    (r_hn && end_ia > {1'b0, r_next.start})) begin
                    n_st = ST_OVERLAP;
                    n_state = S_DONE;
                end else if (mp && ms) begin
                    mem_we = 1'b1;
                    mem_waddr = IDX_W'(r_idx - CNT_W'(1));
                    mem_wdata = '{start: r_prev.start,
                                  size: r_prev.size + r_iz + r_next.size};
                    n_cand = mem_wdata;
                    n_ci = r_idx - CNT_W'(1);
                    n_state = S_DEL_RD;
                end else if (mp) begin
                    mem_we = 1'b1;
                    mem_waddr = IDX_W'(r_idx - CNT_W'(1));
                    mem_wdata = '{start: r_prev.start, size: r_prev.size + r_iz};
                    n_cand = mem_wdata;
                    n_ci = r_idx - CNT_W'(1);
                    n_state = S_INS_OK;
                end else if (ms) begin
                    mem_we = 1'b1;
                    mem_waddr = r_idx[IDX_W-1:0];
                    mem_wdata = '{start: r_ia, size: r_next.size + r_iz};
                    n_cand = mem_wdata;
                    n_ci = r_idx;
                    n_state = S_INS_OK;
                end else if (r_count >= CNT_W'(MAX_REGIONS)) begin
                    n_st = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_cand = '{start: r_ia, size: r_iz};
                    n_ci = r_idx;
                    n_idx = r_count;
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                if (r_idx == r_p) begin
                    mem_we = 1'b1;
                    mem_waddr = r_p[IDX_W-1:0];
                    mem_wdata = r_cand;
                    n_count = r_count + CNT_W'(1);
                    n_state = S_INS_OK;
                end else begin
                    mem_raddr = IDX_W'(r_idx - CNT_W'(1));
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                mem_we = 1'b1;
                mem_waddr = r_idx[IDX_W-1:0];
                mem_wdata = mem_rdata;
                n_idx = r_idx - CNT_W'(1);
                n_state = S_UP_RD;
            end
            S_INS_OK: begin
                if (r_ret == RET_FREE) begin
                    n_st = ST_OK;
                    n_state = S_DONE;
                end else begin
                    n_mapped = r_mapped + CHUNK;
                    n_state = S_G_FIT;
                end
            end
            S_G_TOP: begin
                n_room = T_W'((r_limit - r_mapped) >> GROW_ORDER);
                if (r_limit < r_mapped || (r_limit - r_mapped) < CHUNK) begin
                    n_st = ST_OOM;
                    n_state = S_DONE;
                end else if (r_mapped > ADDR_MASK - r_base) begin
                    n_st = ST_OVERLAP;
                    n_state = S_DONE;
                end else begin
                    n_ia = r_base + r_mapped;
                    n_iz = CHUNK;
                    n_idx = '0;  n_hp = 1'b0;  n_hn = 1'b0;
                    n_ret = RET_GROW;
                    n_state = S_I_RD;
                end
            end
            S_G_EXT: begin
                // extend the region that ends at the mapped top, else map a new chunk
                if (mp) begin
                    n_t = (tt > r_room) ? r_room : tt;
                    n_step = 1'b0;
                    n_state = r_hn ? S_G_APP : S_G_CA;
                end else begin
                    n_state = S_I_DEC;
                end
            end
            S_G_CA: begin
                n_tv = ({15'd0, x} + amask64) & ~amask64;
                n_state = S_G_CB;
            end
            S_G_CB: begin
                n_tv = r_tv + {16'd0, r_req};
                n_state = S_G_CK;
            end
            S_G_CK: begin
                if (r_tv <= {16'd0, r_ia}) begin
                    n_k = '0;
                end else begin
                    n_k = K_W'(((r_tv - {16'd0, r_ia} - 64'd1) >> GROW_ORDER) + 64'd1);
                end
                n_state = S_G_CC;
            end
            S_G_CC: begin
                if (r_step || r_k > K_W'(r_t) || bb <= r_prev.start ||
                    (bb - r_prev.start) >= MIN_SZ) begin
                    n_state = S_G_KFIN;
                end else begin
                    n_step = 1'b1;
                    n_state = S_G_CA;
                end
            end
            S_G_KFIN: begin
                if (kk < K_W'(r_t)) begin
                    n_t = T_W'(kk);
                end
                n_state = S_G_APP;
            end
            S_G_APP: begin
                if (r_t == '0) begin
                    n_state = S_I_DEC;
                end else begin
                    mem_we = 1'b1;
                    mem_waddr = IDX_W'(r_idx - CNT_W'(1));
                    mem_wdata = '{start: r_prev.start, size: r_prev.size + add};
                    n_cand = mem_wdata;
                    n_ci = r_idx - CNT_W'(1);
                    n_mapped = r_mapped + add;
                    n_state = S_G_FIT;
                end
            end
            S_G_FIT: begin
                // only the last region can newly fit
                if (r_ci == r_count - CNT_W'(1) && fit.fits) begin
                    n_have = 1'b1;
                    n_best = r_ci[IDX_W-1:0];
                    n_bent = r_cand;
                    n_bbase = fit.base;
                    n_bwaste = fit.waste;
                    n_state = S_APPLY;
                end else begin
                    n_state = S_G_TOP;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ostat = r_st;
                    n_oga = r_ga;
                    n_ogs = r_gs;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REGIONS))
        else $error("region count above table size");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_state != S_IDLE)
        else $error("accepted transaction not started");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_st != ST_OK |-> r_ga == '0 && r_gs == '0)
        else $error("grant reported on failed request");

endmodule

/* bench/bfra_tb_pkg.sv */
`timescale 1ns / 1ps
package bfra_tb_pkg;

    // configuration register indexes
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

endpackage

/* bench/bfra_checker.sv */
`timescale 1ns / 1ps
module bfra_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_valid,
    input  logic                          i_s_ready,
    input  logic [bfra_pkg::IN_W-1:0]     i_s_data,
    input  logic                          i_m_valid,
    input  logic                          i_m_ready,
    input  logic [bfra_pkg::OUT_W-1:0]    i_m_data,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bfra_pkg::ADDR_W-1:0]   i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);
    import bfra_pkg::*;
    import bfra_tb_pkg::*;

    typedef bit [63:0] t_u64;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
    } t_grant;

    localparam t_u64 AMASK64 = 64'h0000_FFFF_FFFF_FFFF;
    localparam t_u64 CHUNK64 = 64'd1 << GROW_ORDER;
    localparam t_u64 SAT     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_u64 MINR    = 64'(MIN_REGION);

    t_u64 region_start [MAX_REGIONS];
    t_u64 region_len   [MAX_REGIONS];
    int unsigned region_cnt;
    t_u64 heap_mapped;
    t_u64 win_base;
    t_u64 win_limit;
    t_grant expected_grants[$];

    assign o_pending = expected_grants.size();

    function automatic int unsigned slot_after(t_u64 a);
        int unsigned p;
        p = 0;
        while (p < region_cnt && region_start[p] <= a) p++;
        return p;
    endfunction

    function automatic t_status insert_region(t_u64 a, t_u64 sz);
        int unsigned p;
        bit mp, ms;
        t_u64 pe;
        pe = 0;
        if (sz > AMASK64 - a) return ST_OVERLAP;
        p = slot_after(a);
        if (p > 0) begin
            pe = region_start[p-1] + region_len[p-1];
            if (pe > a) return ST_OVERLAP;
        end
        if (p < region_cnt && a + sz > region_start[p]) return ST_OVERLAP;
        mp = p > 0 && pe == a;
        ms = p < region_cnt && a + sz == region_start[p];
        if (mp && ms) begin
            region_len[p-1] += sz + region_len[p];
            for (int unsigned i = p; i + 1 < region_cnt; i++) begin
                region_start[i] = region_start[i+1];
                region_len[i]   = region_len[i+1];
            end
            region_cnt--;
        end else if (mp) begin
            region_len[p-1] += sz;
        end else if (ms) begin
            region_start[p] = a;
            region_len[p] += sz;
        end else begin
            if (region_cnt >= MAX_REGIONS) return ST_FULL;
            for (int unsigned i = region_cnt; i > p; i--) begin
                region_start[i] = region_start[i-1];
                region_len[i]   = region_len[i-1];
            end
            region_start[p] = a;
            region_len[p]   = sz;
            region_cnt++;
        end
        return ST_OK;
    endfunction

    function automatic bit try_place(int unsigned i, t_u64 req, t_u64 am,
                                     output t_u64 b, output t_u64 w);
        t_u64 s, e;
        s = region_start[i];
        b = 0;
        w = 0;
        if (region_len[i] < req) return 0;
        e = s + region_len[i];
        b = (e - req) & ~am;
        if (b < s) return 0;
        if (b != s && b - s < MINR) return 0;
        w = e - b - req;
        return 1;
    endfunction

    function automatic t_u64 round_up(t_u64 x, t_u64 am);
        if (am > ~x) return SAT;
        return (x + am) & ~am;
    endfunction

    function automatic t_u64 chunks_until(t_u64 t, t_u64 req, t_u64 e);
        t_u64 tt;
        if (t == SAT || t > ~req) return SAT;
        tt = t + req;
        if (tt <= e) return 0;
        return (tt - e - 1) / CHUNK64 + 1;
    endfunction

    function automatic t_u64 chunks_for_fit(t_u64 s, t_u64 e, t_u64 req, t_u64 am,
                                            t_u64 cap);
        t_u64 k1, b;
        k1 = chunks_until(round_up(s, am), req, e);
        if (k1 > cap) return k1;
        b = (e + k1 * CHUNK64 - req) & ~am;
        if (b == s || b - s >= MINR) return k1;
        if (s > ~MINR) return SAT;
        return chunks_until(round_up(s + MINR, am), req, e);
    endfunction

    // map more of the window until the topmost region can hold the request
    function automatic t_status extend_heap(t_u64 req, t_u64 am, output int unsigned best,
                                            output t_u64 b, output t_u64 w);
        t_u64 cur, room, lim, t, k;
        int unsigned p;
        t_status st;
        best = 0;
        b = 0;
        w = 0;
        forever begin
            if (win_limit < heap_mapped || win_limit - heap_mapped < CHUNK64)
                return ST_OOM;
            room = (win_limit - heap_mapped) / CHUNK64;
            if (heap_mapped > AMASK64 - win_base) return ST_OVERLAP;
            cur = win_base + heap_mapped;
            p = slot_after(cur);
            if (p > 0 && region_start[p-1] + region_len[p-1] == cur) begin
                lim = p < region_cnt ? region_start[p] - 1 : AMASK64;
                t = (lim - cur) / CHUNK64;
                if (t > room) t = room;
                if (p == region_cnt) begin
                    k = chunks_for_fit(region_start[p-1], cur, req, am, t);
                    if (k == 0) k = 1;
                    if (k < t) t = k;
                end
                if (t > 0) begin
                    region_len[p-1] += t * CHUNK64;
                    heap_mapped += t * CHUNK64;
                    if (try_place(region_cnt - 1, req, am, b, w)) begin
                        best = region_cnt - 1;
                        return ST_OK;
                    end
                    continue;
                end
            end
            st = insert_region(cur, CHUNK64);
            if (st != ST_OK) return st;
            heap_mapped += CHUNK64;
            if (try_place(region_cnt - 1, req, am, b, w)) begin
                best = region_cnt - 1;
                return ST_OK;
            end
        end
    endfunction

    function automatic t_grant predict_request(logic [IN_W-1:0] d);
        t_grant g;
        t_u64 a, req, am, bb, bw, b, w;
        int unsigned best;
        bit have;
        a   = 64'(d[48:1]);
        req = 64'(d[96:49]);
        am  = (64'd1 << d[102:97]) - 1;
        g = '{ST_OK, '0, '0};
        if (d[0] == OP_FREE) begin
            g.status = req < MINR ? ST_SMALL : insert_region(a, req);
        end else begin
            have = 0;
            best = 0;
            bb = 0;
            bw = 0;
            for (int unsigned i = 0; i < region_cnt; i++) begin
                if (!try_place(i, req, am, b, w)) continue;
                if (!have || w <= bw || region_len[best] > region_len[i]) begin
                    have = 1;
                    best = i;
                    bb = b;
                    bw = w;
                    if (w == 0 && region_len[i] == req) break;
                end
            end
            if (!have) g.status = extend_heap(req, am, best, bb, bw);
            if (g.status == ST_OK) begin
                g.addr = bb[ADDR_W-1:0];
                g.size = ADDR_W'(req + bw);
                region_len[best] -= req + bw;
                // drop a region left below the minimum size
                if (region_len[best] < MINR) begin
                    for (int unsigned i = best; i + 1 < region_cnt; i++) begin
                        region_start[i] = region_start[i+1];
                        region_len[i]   = region_len[i+1];
                    end
                    region_cnt--;
                end
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant got, exp_g;
        if (!i_rst_n) begin
            region_cnt  = 0;
            heap_mapped = 0;
            win_base    = 0;
            win_limit   = 0;
            o_errors   <= 0;
            expected_grants.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_HEAP_BASE) win_base = 64'(i_cfg_data);
                else win_limit = 64'(i_cfg_data);
            end
            if (i_s_valid && i_s_ready)
                expected_grants.push_back(predict_request(i_s_data));
            if (i_m_valid && i_m_ready) begin
                got = '{t_status'(i_m_data[2:0]), i_m_data[50:3], i_m_data[98:51]};
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_g = expected_grants.pop_front();
                    if (got.status !== exp_g.status || got.addr !== exp_g.addr ||
                        got.size !== exp_g.size) begin
                        $display("%0t: mismatch expected st=%0d addr=%h size=%h, %s%0d %s%h %s%h",
                                 $time, exp_g.status, exp_g.addr, exp_g.size,
                                 "actual st=", got.status, "addr=", got.addr,
                                 "size=", got.size);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import bfra_pkg::*;
    import bfra_tb_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 600;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_valid;
    logic               s_ready;
    logic [IN_W-1:0]    s_data;
    logic               m_valid;
    logic               m_ready;
    logic [OUT_W-1:0]   m_data;
    logic               cfg_we;
    logic               cfg_idx;
    logic [ADDR_W-1:0]  cfg_data;
    int                 errors;
    int                 pending;
    int                 quiet_cycles;
    int                 rx_mode_left;
    int                 rx_mode;
    logic [ADDR_W-1:0]  held_addr[$];
    logic [ADDR_W-1:0]  held_size[$];

    best_fit_region_allocator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    bfra_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_valid),
        .i_s_ready  (s_ready),
        .i_s_data   (s_data),
        .i_m_valid  (m_valid),
        .i_m_ready  (m_ready),
        .i_m_data   (m_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: switch between stall patterns, including no stalls at all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready      <= 1'b0;
            rx_mode      <= 0;
            rx_mode_left <= 0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(20, 400);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 3) != 0;
                2: m_ready <= $urandom_range(0, 3) == 0;
                default: m_ready <= $urandom_range(0, 40) == 0;
            endcase
        end
    end

    // remember granted blocks so they can be handed back later
    always_ff @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready && m_data[2:0] == ST_OK && m_data[98:51] != 0) begin
            held_addr.push_back(m_data[50:3]);
            held_size.push_back(m_data[98:51]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand48();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [IN_W-1:0] pack_req(logic op, logic [ADDR_W-1:0] a,
                                                 logic [ADDR_W-1:0] sz, logic [5:0] ao);
        return {1'b0, ao, sz, a, op};
    endfunction

    function automatic logic [IN_W-1:0] random_req();
        int r;
        int k;
        logic [ADDR_W-1:0] sz;
        logic [5:0] ao;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            k = $urandom_range(0, 99);
            if (k < 70) sz = ADDR_W'($urandom_range(0, 8192));
            else if (k < 90) sz = ADDR_W'($urandom_range(0, 3 << 20));
            else if (k < 98) sz = ADDR_W'($urandom_range(0, 1 << 24));
            else sz = rand48();
            ao = $urandom_range(0, 9) < 8 ? 6'($urandom_range(0, 12)) : 6'($urandom_range(0, 63));
            return pack_req(OP_ALLOC, rand48(), sz, ao);
        end else if (r < 88 && held_addr.size() > 0) begin
            k = $urandom_range(0, held_addr.size() - 1);
            return pack_req(OP_FREE, held_addr[k], held_size[k], 6'($urandom_range(0, 63)));
        end
        k = $urandom_range(0, 2);
        if (k == 0) return pack_req(OP_FREE, rand48(), rand48(), 6'($urandom));
        if (k == 1) return pack_req(OP_FREE, rand48(), ADDR_W'($urandom_range(0, 40)),
                                    6'($urandom));
        return pack_req(OP_FREE, ADDR_W'($urandom_range(0, 1 << 24)),
                        ADDR_W'($urandom_range(0, 4096)), 6'($urandom));
    endfunction

    task automatic send_item(input logic [IN_W-1:0] d);
        s_valid <= 1'b1;
        s_data  <= d;
        forever begin
            @(negedge i_clk);
            if (s_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic pause_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // bursts of random length, most of them after a random gap
    task automatic run_random(input int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 300));
            end
            send_item(random_req());
            burst--;
        end
    endtask

    initial begin
        s_valid  = 1'b0;
        s_data   = '0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_HEAP_BASE;
        cfg_data = '0;
        i_rst_n  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty window: every allocate runs out of memory
        write_reg(REG_HEAP_BASE, '0);
        write_reg(REG_HEAP_LIMIT, '0);
        send_item(pack_req(OP_ALLOC, '0, 48'd64, 6'd0));
        send_item(pack_req(OP_FREE, '0, 48'd23, 6'd0));
        drain();

        write_reg(REG_HEAP_BASE, 48'h0000_1000_0000);
        write_reg(REG_HEAP_LIMIT, CHUNK * 32);
        send_item(pack_req(OP_ALLOC, '0, 48'd0, 6'd0));
        send_item(pack_req(OP_ALLOC, '1, 48'd0, 6'd12));
        send_item(pack_req(OP_ALLOC, '0, 48'd100, 6'd63));
        send_item(pack_req(OP_ALLOC, '0, 48'd1000, 6'd7));
        send_item(pack_req(OP_ALLOC, '0, CHUNK, 6'd0));
        send_item(pack_req(OP_ALLOC, '0, CHUNK * 3 + 5, 6'd21));
        send_item(pack_req(OP_ALLOC, '0, '1, 6'd0));
        send_item(pack_req(OP_FREE, '1, '1, 6'd63));
        send_item(pack_req(OP_FREE, '0, 48'd0, 6'd0));
        send_item(pack_req(OP_FREE, 48'h1234, 48'd24, 6'd0));
        send_item(pack_req(OP_FREE, 48'h1234, 48'd24, 6'd0));
        send_item(pack_req(OP_FREE, 48'h1240, 48'd32, 6'd0));
        send_item(pack_req(OP_FREE, 48'h124C, 48'd8, 6'd0));
        send_item(pack_req(OP_FREE, 48'hFFFF_FFFF_FFE0, 48'd32, 6'd0));
        send_item(pack_req(OP_FREE, 48'hFFFF_FFFF_FFE0, 48'd31, 6'd0));
        send_item(pack_req(OP_ALLOC, '0, 48'd24, 6'd0));
        send_item(pack_req(OP_ALLOC, '0, 48'd56, 6'd0));
        drain();
        run_random(300);
        drain();

        // window at the very top of the address space
        write_reg(REG_HEAP_BASE, '1 - CHUNK * 4 + 1);
        write_reg(REG_HEAP_LIMIT, '1);
        run_random(230);
        drain();

        write_reg(REG_HEAP_BASE, rand48() & ~(CHUNK - 1));
        write_reg(REG_HEAP_LIMIT, CHUNK * 8);
        run_random(280);
        drain();

        // fill the table with isolated regions until it overflows
        for (int i = 0; i < 70; i++)
            send_item(pack_req(OP_FREE, 48'h100 + 48'(i) * 64, 48'd32, 6'd0));
        send_item(pack_req(OP_FREE, 48'h100 + 48'd70 * 64 + 40, 48'd24, 6'd0));
        send_item(pack_req(OP_FREE, 48'h100 + 32, 48'd32, 6'd0));
        drain();
        write_reg(REG_HEAP_BASE, '0);
        write_reg(REG_HEAP_LIMIT, '1);
        run_random(400);
        drain();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
